// ===== rtl/ssr_pkg.sv =====
// shared constants, request codes and types for the sprite sheet renderer
// no dependencies; imported by the interfaces, the pattern memory and the top level
package ssr_pkg;

  localparam int PATTERN_BYTES   = 8192;
  localparam int PALETTE_ENTRIES = 32;

  // pattern bytes split into two bitplane memories on address bit 3
  localparam int PLANE_DEPTH = PATTERN_BYTES / 2;
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);

  // palette held as rows of four entries
  localparam int PAL_LANES = 4;
  localparam int PAL_ROWS  = PALETTE_ENTRIES / PAL_LANES;
  localparam int PAL_RW    = $clog2(PAL_ROWS);

  localparam int COLOUR_W   = 6;
  localparam int ROW_PIXELS = 8;

  // request codes
  localparam logic [1:0] REQ_RENDER  = 2'd0;
  localparam logic [1:0] REQ_PATTERN = 2'd1;
  localparam logic [1:0] REQ_PALETTE = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TALL_SPRITES = 2'd1;

  // last source row for each sprite height
  localparam logic [3:0] LAST_ROW_SHORT = 4'd7;
  localparam logic [3:0] LAST_ROW_TALL  = 4'd15;

  typedef logic [COLOUR_W-1:0] colour_t;
  typedef colour_t [PAL_LANES-1:0] pal_row_t;

  // write request into the bitplane memories
  typedef struct packed {
    logic                en_lo;
    logic                en_hi;
    logic [PLANE_AW-1:0] idx;
    logic [7:0]          data;
  } pat_wr_t;

endpackage

// ===== rtl/ssr_in_if.sv =====
// request channel: valid/ready handshake with render and write payload
// depends on ssr_pkg
interface ssr_in_if import ssr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  sprite_slot;
  logic [7:0]  tile_number;
  logic [7:0]  sprite_attr;
  logic [12:0] write_address;
  logic [7:0]  write_value;

  modport source (
    output valid, req_type, sprite_slot, tile_number, sprite_attr,
           write_address, write_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, sprite_slot, tile_number, sprite_attr,
           write_address, write_value,
    output ready
  );
endinterface

// ===== rtl/ssr_out_if.sv =====
// result channel: one pixel row of the sheet per beat
// depends on ssr_pkg
interface ssr_out_if import ssr_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic [12:0]                    row_address;
  logic [COLOUR_W*ROW_PIXELS-1:0] row_pixels;
  logic                           last_row;

  modport source (output valid, row_address, row_pixels, last_row, input ready);
  modport sink   (input  valid, row_address, row_pixels, last_row, output ready);
endinterface

// ===== rtl/sprite_sheet_renderer.sv =====
// sprite sheet renderer: one row of eight pixels per beat, 8 or 16 rows per sprite
// a render beat loads the issue stage; each row then passes the read stage and the output register
// throughput: one row per cycle while the output is not stalled, set by the single read port
// of each bitplane memory; the next item is taken on the last row of a sprite
// reset: synchronous, active low; then a clearing pass zeroes the
// pattern store with ready low; palette and configuration clear at once
module sprite_sheet_renderer import ssr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ssr_in_if.sink               in_ch,
  ssr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  // configuration registers
  logic pattern_base_high_r;
  logic tall_sprites_r;

  // clearing pass over the bitplane memories
  logic                clr_busy_r;
  logic [PLANE_AW-1:0] clr_idx_r;

  // palette store, eight rows of four colours
  pal_row_t pal_r [PAL_ROWS];

  // issue stage: walks the rows of the current sprite
  logic       a_busy_r;
  logic [3:0] a_row_r;
  logic       a_tall_r;
  logic [8:0] a_tile_r;
  logic       a_vflip_r;
  logic       a_hflip_r;
  logic [5:0] a_slot_r;
  pal_row_t   a_col_r;

  // read stage: memory data plus the row's side information
  logic        b_vld_r;
  logic [12:0] b_addr_r;
  logic        b_last_r;
  logic        b_hflip_r;
  pal_row_t    b_col_r;
  logic [7:0]  lo_q;
  logic [7:0]  hi_q;

  // output register
  logic                           out_valid_r;
  logic [12:0]                    out_addr_r;
  logic [COLOUR_W*ROW_PIXELS-1:0] out_pix_r;
  logic                           out_last_r;

  logic                           adv;
  logic                           issue;
  logic                           a_last;
  logic                           in_acc;
  logic                           acc_render;
  logic                           acc_pattern;
  logic                           acc_palette;
  logic [3:0]                     dst_row;
  logic [PLANE_AW-1:0]            rd_idx;
  pat_wr_t                        pat_wr;
  logic [COLOUR_W*ROW_PIXELS-1:0] pix_nxt;
  logic [PAL_RW-1:0]              pal_sel;

  // whole pipeline moves when the output register is free or being drained
  assign adv    = !out_valid_r || out_ch.ready;
  assign issue  = a_busy_r && adv;
  assign a_last = (a_row_r == (a_tall_r ? LAST_ROW_TALL : LAST_ROW_SHORT));

  // a new item may enter on the cycle the last row of the previous sprite issues
  assign in_ch.ready = !clr_busy_r && (!a_busy_r || (adv && a_last));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign acc_render  = in_acc && (in_ch.req_type == REQ_RENDER);
  assign acc_pattern = in_acc && (in_ch.req_type == REQ_PATTERN);
  assign acc_palette = in_acc && (in_ch.req_type == REQ_PALETTE);

  // configuration writes, only bit 0 is kept and unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_base_high_r <= 1'b0;
      tall_sprites_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_BASE: pattern_base_high_r <= cfg_data;
        CFG_TALL_SPRITES: tall_sprites_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass, one entry of both planes per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (&clr_idx_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // bit 3 of a pattern address picks the plane, the rest index within it
  always_comb begin
    if (clr_busy_r) begin
      pat_wr.en_lo = 1'b1;
      pat_wr.en_hi = 1'b1;
      pat_wr.idx   = clr_idx_r;
      pat_wr.data  = '0;
    end else begin
      pat_wr.en_lo = acc_pattern && !in_ch.write_address[3];
      pat_wr.en_hi = acc_pattern && in_ch.write_address[3];
      pat_wr.idx   = {in_ch.write_address[12:4], in_ch.write_address[2:0]};
      pat_wr.data  = in_ch.write_value;
    end
  end

  // palette writes keep six bits; address bits 4:2 pick the row, 1:0 the lane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < PAL_ROWS; r++) begin
        pal_r[r] <= '0;
      end
    end else if (acc_palette) begin
      pal_r[in_ch.write_address[4:2]][in_ch.write_address[1:0]] <= in_ch.write_value[5:0];
    end
  end

  // sprite palettes live in the upper half of the store
  assign pal_sel = {1'b1, in_ch.sprite_attr[1:0]};

  // issue stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_busy_r <= 1'b0;
      a_row_r  <= '0;
    end else if (acc_render) begin
      a_busy_r <= 1'b1;
      a_row_r  <= '0;
    end else if (issue) begin
      if (a_last) begin
        a_busy_r <= 1'b0;
      end
      a_row_r <= a_row_r + 1'b1;
    end
  end

  // sprite context; palette colours captured now so later writes do not reach it
  always_ff @(posedge clk) begin
    if (acc_render) begin
      a_tall_r  <= tall_sprites_r;
      // tall: bank from tile bit 0, even tile; short: configured table
      a_tile_r  <= tall_sprites_r ? {in_ch.tile_number[0], in_ch.tile_number[7:1], 1'b0}
                                  : {pattern_base_high_r, in_ch.tile_number};
      a_vflip_r <= in_ch.sprite_attr[7];
      a_hflip_r <= in_ch.sprite_attr[6];
      a_slot_r  <= in_ch.sprite_slot;
      a_col_r   <= {pal_r[pal_sel][3:1], pal_r[0][0]};
    end
  end

  // second tile of a tall sprite is the odd tile, rows 8..15
  assign rd_idx  = {a_tile_r[8:1], a_tile_r[0] | a_row_r[3], a_row_r[2:0]};
  assign dst_row = a_vflip_r ? (a_row_r ^ (a_tall_r ? LAST_ROW_TALL : LAST_ROW_SHORT))
                             : a_row_r;

  ssr_pattern_mem u_pat (
    .clk    (clk),
    .wr     (pat_wr),
    .rd_en  (issue),
    .rd_idx (rd_idx),
    .lo_q   (lo_q),
    .hi_q   (hi_q)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= issue;
    end
  end

  // sheet address: cell row in 12:10, pixel row in 9:6, cell column in 5:3
  always_ff @(posedge clk) begin
    if (issue) begin
      b_addr_r  <= {a_slot_r[5:3], dst_row, a_slot_r[2:0], 3'b000};
      b_last_r  <= a_last;
      b_hflip_r <= a_hflip_r;
      b_col_r   <= a_col_r;
    end
  end

  // bitplane decode: leftmost pixel is bit 7 unless flipped
  always_comb begin
    logic [2:0] b;
    logic [1:0] c;
    pix_nxt = '0;
    for (int j = 0; j < ROW_PIXELS; j++) begin
      b = b_hflip_r ? 3'(j) : ~3'(j);
      c = {hi_q[b], lo_q[b]};
      pix_nxt[COLOUR_W*j +: COLOUR_W] = b_col_r[c];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_vld_r) begin
      out_addr_r <= b_addr_r;
      out_pix_r  <= pix_nxt;
      out_last_r <= b_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.row_address = out_addr_r;
  assign out_ch.row_pixels  = out_pix_r;
  assign out_ch.last_row    = out_last_r;

  // nothing enters while the pattern store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ch.ready)
    else $error("item accepted during clearing pass");

  // a render beat starts the row walk from the first source row
  a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
    acc_render |=> (a_busy_r && (a_row_r == 4'd0)))
    else $error("render beat did not start the row walk");

  // a stalled read stage keeps its memory data
  a_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && !adv) |=> (b_vld_r && $stable(lo_q) && $stable(hi_q)))
    else $error("read stage lost data under stall");

  // the walk over a short sprite never reaches the second tile
  a_short_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (a_busy_r && !a_tall_r) |-> !a_row_r[3])
    else $error("row counter overran an 8x8 sprite");

endmodule

// ===== rtl/ssr_pattern_mem.sv =====
// pattern store as two bitplane memories, one byte of each read per cycle while reads are enabled
// depends on ssr_pkg
module ssr_pattern_mem import ssr_pkg::*; (
  input  logic                clk,
  input  pat_wr_t             wr,
  input  logic                rd_en,
  input  logic [PLANE_AW-1:0] rd_idx,
  output logic [7:0]          lo_q,
  output logic [7:0]          hi_q
);

  logic [7:0] lo_mem [PLANE_DEPTH];
  logic [7:0] hi_mem [PLANE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en_lo) begin
      lo_mem[wr.idx] <= wr.data;
    end
    if (wr.en_hi) begin
      hi_mem[wr.idx] <= wr.data;
    end
  end

  // read data holds while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      lo_q <= lo_mem[rd_idx];
      hi_q <= hi_mem[rd_idx];
    end
  end

endmodule
